FILE: hw/rtl/sor_pkg.sv
// ----------------------------------------------------------------------------
// sor_pkg: shared types and constants for the SOR stencil relaxation block
// Node store sizing, operation codes, register map and divider interface.
// ----------------------------------------------------------------------------
package sor_pkg;

    localparam int NODE_COUNT = 4096;
    localparam int NODE_AW    = $clog2(NODE_COUNT);
    localparam int IDX_W      = 12;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_RELAX = 2'd1;
    localparam logic [1:0] OP_SWEEP = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic REG_RELAX_FACTOR = 1'b0;
    localparam logic REG_SMALL_LIMIT  = 1'b1;

    localparam int DIV_W     = 68;
    localparam int DIVR_W    = 32;
    localparam int DIV_STEPS = DIV_W / 2;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_W-1:0]  quotient;
    } div_rsp_t;

    // Map a 12-bit node index onto a store address, wrapping at the store size.
    function automatic logic [NODE_AW-1:0] slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] m;
        if (NODE_COUNT >= (1 << IDX_W)) begin
            return NODE_AW'(idx);
        end else begin
            m = IDX_W'(idx % NODE_COUNT);
            return NODE_AW'(m);
        end
    endfunction

endpackage

FILE: hw/rtl/sor_div.sv
// ----------------------------------------------------------------------------
// sor_div: radix-4 restoring unsigned divider
// Two quotient bits per cycle; quotient holds until the next start.
// ----------------------------------------------------------------------------
module sor_div import sor_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    typedef enum logic {D_IDLE, D_RUN} dstate_t;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    dstate_t           state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIV_W-1:0]  num_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [DIVR_W-1:0] den_reg;
    logic              done_reg;

    logic [DIVR_W:0]   r1, r2;
    logic              q1, q2;
    logic [DIVR_W-1:0] rem_next;

    always_comb begin
        r1 = {rem_reg, num_reg[DIV_W-1]};
        q1 = (r1 >= {1'b0, den_reg});
        if (q1) begin
            r1 = r1 - {1'b0, den_reg};
        end
        r2 = {r1[DIVR_W-1:0], num_reg[DIV_W-2]};
        q2 = (r2 >= {1'b0, den_reg});
        if (q2) begin
            r2 = r2 - {1'b0, den_reg};
        end
        rem_next = r2[DIVR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE: begin
                    if (req.start) begin
                        num_reg   <= req.dividend;
                        den_reg   <= req.divisor;
                        rem_reg   <= '0;
                        cnt_reg   <= CNT_W'(DIV_STEPS - 1);
                        state_reg <= D_RUN;
                    end
                end
                D_RUN: begin
                    num_reg <= {num_reg[DIV_W-3:0], q1, q2};
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign rsp.busy     = (state_reg == D_RUN);
    assign rsp.done     = done_reg;
    assign rsp.quotient = num_reg;

endmodule

FILE: hw/rtl/sor_stencil_relax_top.sv
// ----------------------------------------------------------------------------
// sor_stencil_relax_top: five-point stencil SOR row update in Q16.16
// Node store in one synchronous RAM, sequenced gather, shared divider.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Word contents
//  s_*      | in        | tuser: operation; tdata: indices, coefs, data_value
//  m_*      | out       | tuser: divide_fault; tdata: node_value, row/max change
//  APB      | in/out    | 0x0 relax_factor, 0x4 small_limit
//
//  A load goes straight to the final state; a read waits for its RAM word.
//  A relax row makes 5 reads on the single RAM read port, then up to two
//  passes through the shared radix-4 divider (quotient term, relative change).
//  One item is in flight at a time; s_tready is high only when idle.
//  The result register holds a finished word while m_tready is low; the
//  sequencer stalls in its final state until that register frees up.
//  Reset is synchronous; the node store is not cleared and needs loads.
// ----------------------------------------------------------------------------
module sor_stencil_relax_top import sor_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [11:0] node_index, [23:12] right_index, [35:24] left_index,
    // [47:36] up_index, [59:48] down_index, [91:60] coef_right,
    // [123:92] coef_left, [155:124] coef_up, [187:156] coef_down,
    // [219:188] coef_middle, [251:220] data_value, [255:252] zero
    input  logic [255:0] s_tdata,
    // [1:0] operation
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] node_value, [62:32] row_change, [93:63] max_change, [95:94] zero
    output logic [95:0]  m_tdata,
    // [0] divide_fault
    output logic         m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    typedef enum logic [3:0] {
        T_IDLE, T_READ, T_GATHER, T_DIFF, T_SCALE, T_QWAIT,
        T_TOTAL, T_CHECK, T_CWAIT, T_FIN
    } tstate_t;

    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] NEG_MIN = 32'sh8000_0000;
    localparam logic [30:0]        ROW_MAX = 31'h7FFF_FFFF;

    // ---------------- configuration registers ----------------
    logic [17:0] relax_factor_reg;
    logic [16:0] small_limit_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            relax_factor_reg <= 18'd65536;
            small_limit_reg  <= 17'd1;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_RELAX_FACTOR: relax_factor_reg <= pwdata[17:0];
                REG_SMALL_LIMIT:  small_limit_reg  <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_RELAX_FACTOR: prdata = {14'd0, relax_factor_reg};
            REG_SMALL_LIMIT:  prdata = {15'd0, small_limit_reg};
            default:          prdata = '0;
        endcase
    end

    // ---------------- node store ----------------
    logic [31:0]        node_mem [NODE_COUNT];
    logic [NODE_AW-1:0] rd_addr;
    logic [31:0]        rdata_reg;
    logic               mem_we;
    logic [NODE_AW-1:0] wr_addr;
    logic [31:0]        wr_data;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            node_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= node_mem[rd_addr];
    end

    // ---------------- sequencer state ----------------
    tstate_t                 state_reg;
    logic [2:0]              cnt_reg;
    logic [1:0]              op_reg;
    logic [NODE_AW-1:0]      node_reg;
    logic [NODE_AW-1:0]      nb_reg [4];
    logic signed [31:0]      cf_reg [4];
    logic signed [31:0]      cm_reg;
    logic signed [31:0]      rhs_reg;
    logic signed [31:0]      xo_reg;
    logic signed [63:0]      prod_reg;
    logic signed [49:0]      sum_reg;
    logic signed [34:0]      term_reg;
    logic                    d_neg_reg;
    logic [48:0]             dm_reg;
    logic signed [31:0]      new_reg;
    logic [30:0]             row_reg;
    logic                    fault_reg;
    logic                    max_valid_reg;
    logic [30:0]             max_reg;
    logic                    m_valid_reg;
    logic [93:0]             m_data_reg;
    logic                    m_fault_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    sor_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    logic               s_fire;
    logic               out_free;
    logic               fin_fire;
    logic               is_relax;
    logic [1:0]         cnt_m1;
    logic signed [50:0] d_full;
    logic [31:0]        cm_mag;
    logic signed [18:0] one_minus_w;
    logic [40:0]        q_cap;
    logic signed [42:0] tot_full;
    logic signed [32:0] xo_minus_new;
    logic [32:0]        dmag;
    logic               below_limit;
    logic               max_take;
    logic [30:0]        max_upd;

    assign s_tready = (state_reg == T_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign fin_fire = (state_reg == T_FIN) && out_free;
    assign is_relax = (op_reg == OP_RELAX) || (op_reg == OP_SWEEP);
    assign cnt_m1   = 2'(cnt_reg - 3'd1);

    always_comb begin
        d_full       = 51'(rhs_reg) - 51'(sum_reg);
        cm_mag       = cm_reg[31] ? 32'(-33'(cm_reg)) : 32'(cm_reg);
        one_minus_w  = 19'sd65536 - $signed({1'b0, relax_factor_reg});
        // Clamp the quotient term; anything beyond 2^40 saturates anyway.
        if (div_rsp.quotient[DIV_W-1:41] != '0 ||
            (div_rsp.quotient[40] && div_rsp.quotient[39:0] != '0)) begin
            q_cap = 41'h100_0000_0000;
        end else begin
            q_cap = div_rsp.quotient[40:0];
        end
        tot_full     = (d_neg_reg != cm_reg[31]) ? -43'($signed({1'b0, q_cap}))
                                                 :  43'($signed({1'b0, q_cap}));
        tot_full     = tot_full + 43'(term_reg);
        xo_minus_new = 33'(xo_reg) - 33'(new_reg);
        dmag         = xo_minus_new[32] ? 33'(-xo_minus_new) : 33'(xo_minus_new);
        below_limit  = (33'(new_reg) < $signed({16'd0, small_limit_reg}));
    end

    // Read address: node on acceptance, then the four neighbors in turn.
    always_comb begin
        if (state_reg == T_GATHER) begin
            rd_addr = nb_reg[cnt_reg[1:0]];
        end else begin
            rd_addr = slot(s_tdata[11:0]);
        end
    end

    // Shared divider: quotient term first, relative change second.
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(dm_reg) * DIV_W'(relax_factor_reg);
        div_req.divisor  = cm_mag;
        if (state_reg == T_SCALE) begin
            div_req.start = (cm_reg != '0);
        end else if (state_reg == T_CHECK) begin
            div_req.start    = !below_limit && (new_reg != '0);
            div_req.dividend = DIV_W'({dmag, 16'd0});
            div_req.divisor  = 32'(new_reg);
        end
    end

    // Sweep maximum update for the word being delivered.
    always_comb begin
        max_take = (op_reg == OP_SWEEP) || !max_valid_reg || (row_reg > max_reg);
        max_upd  = (is_relax && max_take) ? row_reg : max_reg;
    end

    assign mem_we  = fin_fire && (op_reg != OP_READ);
    assign wr_addr = node_reg;
    assign wr_data = new_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= T_IDLE;
            cnt_reg       <= '0;
            max_valid_reg <= 1'b0;
            max_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE: begin
                    if (s_fire) begin
                        // Latch the word; the node read is already issued.
                        op_reg    <= s_tuser;
                        node_reg  <= slot(s_tdata[11:0]);
                        nb_reg[0] <= slot(s_tdata[23:12]);
                        nb_reg[1] <= slot(s_tdata[35:24]);
                        nb_reg[2] <= slot(s_tdata[47:36]);
                        nb_reg[3] <= slot(s_tdata[59:48]);
                        cf_reg[0] <= s_tdata[91:60];
                        cf_reg[1] <= s_tdata[123:92];
                        cf_reg[2] <= s_tdata[155:124];
                        cf_reg[3] <= s_tdata[187:156];
                        cm_reg    <= s_tdata[219:188];
                        rhs_reg   <= s_tdata[251:220];
                        new_reg   <= s_tdata[251:220];
                        row_reg   <= '0;
                        fault_reg <= 1'b0;
                        sum_reg   <= '0;
                        cnt_reg   <= '0;
                        case (s_tuser)
                            OP_LOAD:  state_reg <= T_FIN;
                            OP_READ:  state_reg <= T_READ;
                            default:  state_reg <= T_GATHER;
                        endcase
                    end
                end
                T_READ: begin
                    new_reg   <= rdata_reg;
                    state_reg <= T_FIN;
                end
                T_GATHER: begin
                    // cnt 0: old node value; cnt 1..4: neighbors; products are registered, then accumulated.
                    if (cnt_reg == 3'd0) begin
                        xo_reg <= rdata_reg;
                    end
                    if (cnt_reg == 3'd1) begin
                        term_reg <= 35'((64'(one_minus_w) * 64'(xo_reg)) >>> 16);
                    end
                    if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4) begin
                        prod_reg <= 64'($signed(rdata_reg)) * 64'(cf_reg[cnt_m1]);
                    end
                    if (cnt_reg >= 3'd2) begin
                        sum_reg <= sum_reg + 50'(prod_reg >>> 16);
                    end
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd5) begin
                        state_reg <= T_DIFF;
                    end
                end
                T_DIFF: begin
                    d_neg_reg <= d_full[50];
                    dm_reg    <= d_full[50] ? 49'(-d_full) : 49'(d_full);
                    state_reg <= T_SCALE;
                end
                T_SCALE: begin
                    if (cm_reg == '0) begin
                        fault_reg <= 1'b1;
                        new_reg   <= (relax_factor_reg == '0 || !d_neg_reg) ? POS_MAX
                                                                             : NEG_MIN;
                        state_reg <= T_CHECK;
                    end else begin
                        state_reg <= T_QWAIT;
                    end
                end
                T_QWAIT: begin
                    if (div_rsp.done) begin
                        state_reg <= T_TOTAL;
                    end
                end
                T_TOTAL: begin
                    if (tot_full > 43'(POS_MAX)) begin
                        new_reg <= POS_MAX;
                    end else if (tot_full < 43'(NEG_MIN)) begin
                        new_reg <= NEG_MIN;
                    end else begin
                        new_reg <= 32'(tot_full);
                    end
                    state_reg <= T_CHECK;
                end
                T_CHECK: begin
                    if (below_limit) begin
                        row_reg   <= '0;
                        state_reg <= T_FIN;
                    end else if (new_reg == '0) begin
                        row_reg   <= ROW_MAX;
                        state_reg <= T_FIN;
                    end else begin
                        state_reg <= T_CWAIT;
                    end
                end
                T_CWAIT: begin
                    if (div_rsp.done) begin
                        row_reg   <= (div_rsp.quotient[DIV_W-1:31] != '0) ? ROW_MAX
                                                                          : div_rsp.quotient[30:0];
                        state_reg <= T_FIN;
                    end
                end
                T_FIN: begin
                    // Hold until the result register frees up, then deliver and write back.
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {(is_relax || max_valid_reg) ? max_upd : 31'd0,
                                        row_reg, new_reg};
                        m_fault_reg <= fault_reg;
                        if (is_relax) begin
                            max_valid_reg <= 1'b1;
                            max_reg       <= max_upd;
                        end
                        state_reg <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_data_reg};
    assign m_tuser  = m_fault_reg;

    // ---------------- assertions ----------------
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> !(m_valid_reg && $changed(m_data_reg)))
        else $error("result word overwritten while stalled");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_fault_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[31:0] == 32'h7FFF_FFFF ||
                                   m_tdata[31:0] == 32'h8000_0000))
        else $error("divide fault without saturated value");

    a_row_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[62:32] <= m_tdata[93:63]))
        else $error("row change exceeds sweep maximum");

    a_relax_sets_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_fire && is_relax) |=> max_valid_reg)
        else $error("sweep maximum not marked after relax row");

endmodule

FILE: dv/sor_stencil_relax_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sor_stencil_relax_top_tb: self-checking bench for the SOR stencil row block
// Loads nodes, relaxes rows and reads nodes back over the stream ports. The
// bench keeps its own copy of the node store and computes every result word
// in Q16.16 fixed point. Relax factor and small limit are changed over APB
// between phases.
// ----------------------------------------------------------------------------
module sor_stencil_relax_top_tb;
    import sor_pkg::*;

    // Input word, split into fields before packing onto tdata/tuser.
    typedef struct {
        logic [1:0]  op;
        logic [11:0] idx[5];        // node, right, left, up, down
        logic [31:0] coef[5];       // right, left, up, down, middle
        logic [31:0] data;
    } row_item_t;

    typedef struct {
        logic [31:0] node_value;
        logic [30:0] row_change;
        logic [30:0] max_change;
        logic        fault;
    } row_result_t;

    localparam int    RELAX_CYCLES = 100;
    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint NEG_MIN = -64'sd2147483648;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [255:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic         m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    sor_stencil_relax_top uut (.*);

    // Clock: 20 ns period.
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Predictor state: node store shadow, written flags, sweep maximum, registers.
    logic [31:0] node_shadow[NODE_COUNT];
    bit          node_written[NODE_COUNT];
    longint      sweep_peak;
    longint      weight;
    longint      zero_limit;

    row_item_t   word_queue[$];       // words waiting for the driver
    row_result_t expected_words[$];   // results still owed by the block

    int  mismatches;
    int  results_seen;
    int  relax_rows;
    int  fault_rows;
    bit  send_quiet;   // disable sender gaps
    bit  recv_quiet;   // disable receiver stalls

    function automatic longint floor_q16(longint v);
        if (v >= 0) begin
            return v >>> 16;
        end
        return -((-v + 65535) >>> 16);
    endfunction

    function automatic longint sx32(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    // Compute the result word for one item and update the shadow state.
    function automatic row_result_t predict_row(row_item_t it);
        row_result_t r;
        longint      xo, sum, d, cm, term, tot, qs, df, row;
        longint unsigned dm, cmag, q, rem, qm, dmag, rr;
        int          n;
        n = it.idx[0];
        r.fault = 1'b0;
        row = 0;
        if (it.op == OP_LOAD) begin
            node_shadow[n] = it.data;
            node_written[n] = 1'b1;
            tot = sx32(it.data);
        end else if (it.op == OP_READ) begin
            tot = sx32(node_shadow[n]);
        end else begin
            xo = sx32(node_shadow[n]);
            sum = 0;
            if (it.op == OP_SWEEP) begin
                sweep_peak = -1;
            end
            for (int k = 1; k < 5; k++) begin
                sum += floor_q16(sx32(node_shadow[it.idx[k]]) * sx32(it.coef[k-1]));
            end
            d = sx32(it.data) - sum;
            cm = sx32(it.coef[4]);
            term = floor_q16((65536 - weight) * xo);
            if (cm == 0) begin
                r.fault = 1'b1;
                tot = (weight == 0 || d >= 0) ? POS_MAX : NEG_MIN;
            end else begin
                dm = d < 0 ? -d : d;
                cmag = cm < 0 ? -cm : cm;
                q = dm / cmag;
                rem = dm % cmag;
                if (weight == 0) begin
                    qm = 0;
                end else if (q > (64'd1 << 40)) begin
                    qm = 64'd1 << 40;
                end else begin
                    qm = q * weight + (rem * weight) / cmag;
                end
                qs = longint'(qm);
                if ((d < 0) != (cm < 0)) begin
                    qs = -qs;
                end
                tot = qs + term;
                if (tot > POS_MAX) tot = POS_MAX;
                if (tot < NEG_MIN) tot = NEG_MIN;
            end
            if (tot < zero_limit) begin
                row = 0;
            end else if (tot == 0) begin
                row = POS_MAX;
            end else begin
                df = xo - tot;
                dmag = df < 0 ? -df : df;
                rr = (dmag << 16) / longint'(tot);
                row = rr > POS_MAX ? POS_MAX : longint'(rr);
            end
            if (row > sweep_peak) begin
                sweep_peak = row;
            end
            node_shadow[n] = tot[31:0];
            node_written[n] = 1'b1;
        end
        r.node_value = tot[31:0];
        r.row_change = row[30:0];
        r.max_change = sweep_peak < 0 ? 31'd0 : sweep_peak[30:0];
        return r;
    endfunction

    // Queue a word for the driver and its predicted result.
    task automatic push_word(row_item_t it);
        row_result_t r;
        word_queue.push_back(it);
        r = predict_row(it);
        expected_words.push_back(r);
        if (it.op == OP_RELAX || it.op == OP_SWEEP) begin
            relax_rows++;
        end
        if (r.fault) begin
            fault_rows++;
        end
    endtask

    function automatic logic [11:0] pick_written();
        int n;
        do begin
            n = $urandom_range(NODE_COUNT - 1);
        end while (!node_written[n]);
        return n[11:0];
    endfunction

    // Small working set of nodes keeps neighbours defined; occasional wide index.
    function automatic logic [11:0] pick_node();
        if ($urandom_range(9) == 0) begin
            return $urandom_range(4095);
        end
        return $urandom_range(31);
    endfunction

    function automatic logic [31:0] pick_q16();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return 32'($signed($urandom_range(8 * 65536)) - 4 * 65536);
        endcase
    endfunction

    function automatic row_item_t load_item(logic [11:0] n, logic [31:0] v);
        row_item_t it;
        it.op = OP_LOAD;
        foreach (it.idx[k]) it.idx[k] = $urandom();
        foreach (it.coef[k]) it.coef[k] = $urandom();
        it.idx[0] = n;
        it.data = v;
        return it;
    endfunction

    function automatic row_item_t relax_item(logic [1:0] op, logic [11:0] n);
        row_item_t it;
        it.op = op;
        it.idx[0] = n;
        for (int k = 1; k < 5; k++) it.idx[k] = pick_written();
        for (int k = 0; k < 4; k++) begin
            it.coef[k] = ($urandom_range(3) == 0) ? pick_q16()
                       : 32'($signed($urandom_range(65536)) - 32768);
        end
        it.coef[4] = ($urandom_range(15) == 0) ? 32'd0 : pick_q16();
        if (it.coef[4] != 0 && $urandom_range(1)) begin
            it.coef[4] = 32'd4 << 16;
        end
        it.data = pick_q16();
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present queued words on the input channel, with random gaps.
    // Inputs change on the falling edge; acceptance is seen at the rising edge.
    // ------------------------------------------------------------------------
    int  send_gap;
    bit  send_hold;    // pause requested by the stimulus
    bit  in_taken;     // input word accepted at the last rising edge

    always @(posedge aclk) begin
        in_taken <= aresetn && s_tvalid && s_tready;
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_taken) begin
            // hold the current word until it is taken
        end else begin
            if (in_taken) begin
                void'(word_queue.pop_front());
            end
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (!send_quiet && $urandom_range(7) == 0) begin
                send_gap = $urandom_range(18) - 1;
                s_tvalid <= 1'b0;
            end else if (word_queue.size() > 0 && !send_hold) begin
                row_item_t it;
                it = word_queue[0];
                s_tuser <= it.op;
                s_tdata <= {4'd0, it.data, it.coef[4], it.coef[3], it.coef[2],
                            it.coef[1], it.coef[0], it.idx[4], it.idx[3],
                            it.idx[2], it.idx[1], it.idx[0]};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Track the accepted word separately so pops line up with handshakes.
    // The driver pops when it sees a taken word on the next falling edge.

    // ------------------------------------------------------------------------
    // Receiver: random backpressure on m_tready, changed on the falling edge.
    // ------------------------------------------------------------------------
    int recv_gap;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_tready <= 1'b0;
        end else if (!recv_quiet && $urandom_range(5) == 0) begin
            recv_gap = $urandom_range(18) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each accepted result word with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            row_result_t want;
            results_seen++;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result word %h", m_tdata);
                end
            end else begin
                want = expected_words.pop_front();
                if (m_tdata[31:0] !== want.node_value || m_tdata[62:32] !== want.row_change
                    || m_tdata[93:63] !== want.max_change || m_tuser !== want.fault) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: want value %h row %h max %h fault %b",
                                 want.node_value, want.row_change, want.max_change,
                                 want.fault);
                        $display("          got  value %h row %h max %h fault %b",
                                 m_tdata[31:0], m_tdata[62:32], m_tdata[93:63], m_tuser);
                    end
                end
            end
        end
    end

    // APB write: setup cycle then access cycle.
    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == 3'd0) weight = value[17:0];
        else zero_limit = value[16:0];
    endtask

    // Wait for all queued words to be taken and their results returned.
    task automatic drain();
        while (word_queue.size() > 0 || s_tvalid || expected_words.size() > 0) begin
            @(posedge aclk);
        end
        repeat (RELAX_CYCLES) @(posedge aclk);
    endtask

    task automatic random_phase(int count);
        row_item_t it;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(9))
                0, 1: push_word(load_item(pick_node(), pick_q16()));
                2: begin
                    it = load_item(pick_written(), 32'd0);
                    it.op = OP_READ;
                    push_word(it);
                end
                3: push_word(relax_item(OP_SWEEP, pick_written()));
                default: push_word(relax_item(OP_RELAX, pick_written()));
            endcase
            // Keep the queue short so gaps spread over the whole run.
            while (word_queue.size() > 4) @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        row_item_t it;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_LOAD;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        weight = 65536;
        zero_limit = 1;
        sweep_peak = -1;
        mismatches = 0;
        results_seen = 0;
        relax_rows = 0;
        fault_rows = 0;
        send_gap = 0;
        recv_gap = 0;
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
        send_hold = 1'b0;
        foreach (node_written[i]) node_written[i] = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes of values and indices, every operation.
        write_reg(3'd0, 32'd65536);
        write_reg(3'd4, 32'd1);
        for (int k = 0; k < 8; k++) push_word(load_item(k, 32'(k) << 16));
        push_word(load_item(12'hFFF, 32'h7FFF_FFFF));
        push_word(load_item(12'hFFE, 32'h8000_0000));
        it = relax_item(OP_SWEEP, 12'd0);
        it.idx[1] = 12'hFFF; it.idx[2] = 12'hFFE;
        it.coef[0] = 32'hFFFF_FFFF; it.coef[1] = 32'h8000_0000;
        push_word(it);
        it = relax_item(OP_RELAX, 12'd1);
        it.coef[4] = 32'd0;                        // zero divisor
        it.data = 32'h7FFF_FFFF;
        push_word(it);
        it = relax_item(OP_RELAX, 12'd2);
        it.coef[4] = 32'd0; it.data = 32'h8000_0000;
        foreach (it.coef[k]) if (k < 4) it.coef[k] = 32'd0;
        push_word(it);                             // negative zero-divisor case
        it = relax_item(OP_RELAX, 12'd3);
        it.coef[4] = 32'h0000_0001;
        it.data = 32'h7FFF_FFFF;                   // huge quotient, saturation
        push_word(it);
        it = load_item(12'hFFF, 32'd0); it.op = OP_READ; push_word(it);
        it = load_item(12'd0, 32'd0);   it.op = OP_READ; push_word(it);
        drain();

        // Zero weight and zero limit: new value of zero gives a saturated change.
        write_reg(3'd0, 32'd0);
        write_reg(3'd4, 32'd0);
        push_word(load_item(12'd5, 32'd0));
        it = relax_item(OP_SWEEP, 12'd5);
        push_word(it);
        it = relax_item(OP_RELAX, 12'd6);
        it.coef[4] = 32'd0;
        push_word(it);
        drain();

        // Random phases across register settings, extremes included.
        write_reg(3'd0, 32'd131072);
        write_reg(3'd4, 32'd65536);
        random_phase(120);
        // Pause until every result is back, then carry on.
        while (word_queue.size() > 0) @(posedge aclk);
        send_hold = 1'b1;
        while (expected_words.size() > 0) @(posedge aclk);
        send_hold = 1'b0;
        random_phase(30);
        drain();
        write_reg(3'd0, 32'h3FFFF);                // weight above 2.0
        write_reg(3'd4, 32'd0);
        random_phase(120);
        drain();
        write_reg(3'd0, $urandom_range(131072));
        write_reg(3'd4, $urandom_range(65536));
        random_phase(120);
        drain();

        // Final stretch with no idling on either side.
        send_quiet = 1'b1;
        recv_quiet = 1'b1;
        write_reg(3'd0, 32'd98304);
        write_reg(3'd4, 32'd1);
        random_phase(110);
        drain();

        $display("Ran %0d result words, %0d relax rows, over six register settings.",
                 results_seen, relax_rows);
        $display("Zero-divisor rows seen: %0d.", fault_rows);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatching words", mismatches);
            $display("FAILURE");
        end
        $finish;
    end

    // Timeout guard.
    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule
